@@ rtl/lfv_pkg.sv @@
// ----------------------------------------------------------------------------
// lfv_pkg
// Shared types and constants for the LRU frame victim selector: request and
// result payloads, mode codes, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lfv_pkg;

    // Fixed field widths of the request and result payloads
    localparam int FRAME_W = 4;
    localparam int PAGE_W  = 10;
    localparam int TIME_W  = 32;

    // Default storage geometry
    localparam int FRAME_COUNT_DEF = 16;
    localparam int PAGE_BITS_DEF   = 10;
    localparam int STAMP_BITS_DEF  = 32;

    // Request modes
    typedef enum logic [1:0] {
        MODE_ASSIGN  = 2'd0,
        MODE_ACCESS  = 2'd1,
        MODE_REPLACE = 2'd2
    } t_mode;

    // Request payload
    typedef struct packed {
        logic [1:0]         mode;
        logic [FRAME_W-1:0] frame_number;
        logic [PAGE_W-1:0]  page_number;
        logic [TIME_W-1:0]  access_time;
        logic               write_access;
    } t_item;

    // Result payload
    typedef struct packed {
        logic [FRAME_W-1:0] victim_frame;
        logic [PAGE_W-1:0]  victim_page;
        logic               needs_write_back;
        logic               list_empty_error;
    } t_result;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_SEARCH,
        ST_SHIFT
    } t_state;

    // What the datapath does with each entry read during a scan
    typedef enum logic [1:0] {
        PH_ACCESS,
        PH_SEARCH,
        PH_SHIFT
    } t_phase;

    // Controller to datapath
    typedef struct packed {
        logic   take;        // latch the request
        logic   append;      // write a new entry at the tail
        logic   scan_init;   // restart the scan at entry 0
        logic   shift_init;  // restart the scan just after the victim
        logic   step;        // issue the next read, handle the previous one
        t_phase phase;
        logic   emit;        // post the victim and drop it from the list
        logic   emit_err;    // post an empty-list error
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic issued_all;    // no entries left to read
        logic rd_vld;        // read data pending this cycle
    } t_status;

endpackage

@@ rtl/lfv_ram.sv @@
// ----------------------------------------------------------------------------
// lfv_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module lfv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/lfv_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfv_ctrl
// Sequencer for the victim selector: decodes each request and walks the
// datapath through the access scan, the victim search and the list shift.
// ----------------------------------------------------------------------------
module lfv_ctrl
    import lfv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_mode,
    input  t_status    i_status,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;
    logic   scan_done;

    // Scan is over once every entry is read and the last read is handled
    assign scan_done = i_status.issued_all && !i_status.rd_vld;

    assign o_busy = (r_state != ST_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.phase   = PH_ACCESS;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_mode)
                        MODE_ASSIGN: begin
                            o_cmd.append = !i_status.full;
                        end
                        MODE_ACCESS: begin
                            o_cmd.take      = 1'b1;
                            o_cmd.scan_init = 1'b1;
                            n_state         = ST_ACCESS;
                        end
                        MODE_REPLACE: begin
                            if (i_status.empty) begin
                                o_cmd.emit_err = 1'b1;
                            end else begin
                                o_cmd.take      = 1'b1;
                                o_cmd.scan_init = 1'b1;
                                n_state         = ST_SEARCH;
                            end
                        end
                        default: begin
                            // unused mode: drop the request
                        end
                    endcase
                end
            end
            ST_ACCESS: begin
                o_cmd.phase = PH_ACCESS;
                if (scan_done) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_SEARCH: begin
                o_cmd.phase = PH_SEARCH;
                if (scan_done) begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = ST_SHIFT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_SHIFT: begin
                o_cmd.phase = PH_SHIFT;
                if (scan_done) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/lfv_datapath.sv @@
// ----------------------------------------------------------------------------
// lfv_datapath
// Entry storage and scan datapath: appends entries, refreshes matching
// entries, searches for the oldest stamp, closes the gap left by the victim
// and registers the result.
// ----------------------------------------------------------------------------
module lfv_datapath
    import lfv_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF,
    parameter int STAMP_BITS  = STAMP_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_cmd    i_cmd,
    output t_status o_status,
    output t_result o_result,
    output logic    o_res_vld
);

    localparam int IDX_W     = $clog2(FRAME_COUNT);
    localparam int CNT_W     = $clog2(FRAME_COUNT + 1);
    localparam int ENT_W     = FRAME_W + PAGE_BITS + STAMP_BITS + 1;
    localparam int STAMP_LSB = 1;
    localparam int PAGE_LSB  = STAMP_LSB + STAMP_BITS;
    localparam int FRAME_LSB = PAGE_LSB + PAGE_BITS;

    // Control registers
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_addr;
    logic [IDX_W-1:0]      r_rd_idx;
    logic                  r_rd_vld;
    logic                  r_res_vld;

    // Latched request
    logic [PAGE_BITS-1:0]  r_page;
    logic [STAMP_BITS-1:0] r_stamp;
    logic                  r_wr;

    // Search state
    logic [STAMP_BITS-1:0] r_best;
    logic [IDX_W-1:0]      r_pick;
    logic [FRAME_W-1:0]    r_pick_frame;
    logic [PAGE_BITS-1:0]  r_pick_page;
    logic                  r_pick_dirty;
    t_result               r_res;

    // RAM ports
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [ENT_W-1:0]      wr_data;
    logic                  rd_en;
    logic [ENT_W-1:0]      rd_data;

    // Read entry fields
    logic [FRAME_W-1:0]    rd_frame;
    logic [PAGE_BITS-1:0]  rd_page;
    logic [STAMP_BITS-1:0] rd_stamp;
    logic                  rd_dirty;
    logic                  issued_all;
    logic                  handle;
    logic                  take_best;

    assign rd_frame = rd_data[FRAME_LSB +: FRAME_W];
    assign rd_page  = rd_data[PAGE_LSB +: PAGE_BITS];
    assign rd_stamp = rd_data[STAMP_LSB +: STAMP_BITS];
    assign rd_dirty = rd_data[0];

    assign issued_all = (r_addr >= r_count);
    assign rd_en      = i_cmd.step && !issued_all;
    assign handle     = i_cmd.step && r_rd_vld;

    // Later entries win ties, so compare with less-or-equal
    assign take_best  = handle && (i_cmd.phase == PH_SEARCH)
                        && ((r_rd_idx == '0) || (rd_stamp <= r_best));

    assign o_status.empty      = (r_count == '0);
    assign o_status.full       = (r_count == CNT_W'(FRAME_COUNT));
    assign o_status.issued_all = issued_all;
    assign o_status.rd_vld     = r_rd_vld;

    // Select the write: append, refresh a matching entry, or shift down
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[IDX_W-1:0];
        wr_data = {i_item.frame_number, PAGE_BITS'(i_item.page_number),
                   STAMP_BITS'(i_item.access_time), 1'b0};
        if (i_cmd.append) begin
            wr_en = 1'b1;
        end else if (handle) begin
            case (i_cmd.phase)
                PH_ACCESS: begin
                    wr_en   = (rd_page == r_page);
                    wr_addr = r_rd_idx;
                    wr_data = {rd_frame, rd_page, r_stamp, rd_dirty | r_wr};
                end
                PH_SHIFT: begin
                    wr_en   = 1'b1;
                    wr_addr = r_rd_idx - IDX_W'(1);
                    wr_data = rd_data;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    lfv_ram #(
        .WIDTH (ENT_W),
        .DEPTH (FRAME_COUNT)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Advance the scan, track the entry count and the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= i_cmd.emit || i_cmd.emit_err;
            r_rd_vld  <= rd_en;
            if (i_cmd.scan_init) begin
                r_addr <= '0;
            end else if (i_cmd.shift_init) begin
                r_addr <= CNT_W'(r_pick) + CNT_W'(1);
            end else if (rd_en) begin
                r_addr <= r_addr + CNT_W'(1);
            end
            if (i_cmd.append) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.emit) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Hold the request, the read index and the best candidate so far
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_page  <= PAGE_BITS'(i_item.page_number);
            r_stamp <= STAMP_BITS'(i_item.access_time);
            r_wr    <= i_item.write_access;
        end
        if (rd_en) begin
            r_rd_idx <= r_addr[IDX_W-1:0];
        end
        if (take_best) begin
            r_best       <= rd_stamp;
            r_pick       <= r_rd_idx;
            r_pick_frame <= rd_frame;
            r_pick_page  <= rd_page;
            r_pick_dirty <= rd_dirty;
        end
        if (i_cmd.emit) begin
            r_res.victim_frame     <= r_pick_frame;
            r_res.victim_page      <= PAGE_W'(r_pick_page);
            r_res.needs_write_back <= r_pick_dirty;
            r_res.list_empty_error <= 1'b0;
        end else if (i_cmd.emit_err) begin
            r_res.victim_frame     <= '0;
            r_res.victim_page      <= '0;
            r_res.needs_write_back <= 1'b0;
            r_res.list_empty_error <= 1'b1;
        end
    end

    assign o_result  = r_res;
    assign o_res_vld = r_res_vld;

endmodule

@@ rtl/lru_frame_victim_select_core.sv @@
// ----------------------------------------------------------------------------
// lru_frame_victim_select_core
// LRU page-frame victim selector: keeps the occupied frames in assignment
// order and picks the least recently used one on a replacement request.
// ----------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy is low. An assign and a
// replacement on an empty list leave o_busy low. An access, or a replacement
// on a non-empty list, keeps o_busy high while the entry RAM is walked one
// entry per cycle through its registered read port, once to refresh or
// search and, on a replacement, once more to close the gap behind the
// victim. Only a replacement gives a result: it shows on o_result for exactly
// one cycle with o_res_vld high, in the first cycle that busy is low again
// (or in the cycle right after the request when the list is empty), and must
// be captured then, since it cannot be held off. Entries hold nothing until
// assigned, so no clearing pass is needed after reset.
module lru_frame_victim_select_core
    import lfv_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF,
    parameter int STAMP_BITS  = STAMP_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_item   i_item,
    output logic    o_busy,
    output logic    o_res_vld,
    output t_result o_result
);

    t_cmd    cmd;
    t_status status;

    // Sequencer
    lfv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_mode   (i_item.mode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    // Storage and scan datapath
    lfv_datapath #(
        .FRAME_COUNT (FRAME_COUNT),
        .PAGE_BITS   (PAGE_BITS),
        .STAMP_BITS  (STAMP_BITS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_cmd     (cmd),
        .o_status  (status),
        .o_result  (o_result),
        .o_res_vld (o_res_vld)
    );

endmodule

@@ rtl/lfv_checker.sv @@
// ----------------------------------------------------------------------------
// lfv_checker
// Port-level checks for the LRU frame victim selector, bound to the top.
// ----------------------------------------------------------------------------
module lfv_checker
    import lfv_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_start,
    input t_item   i_item,
    input logic    o_busy,
    input logic    o_res_vld,
    input t_result o_result
);

    logic req_acc;
    logic req_rep;

    assign req_acc = i_start && !o_busy;
    assign req_rep = req_acc && (i_item.mode == MODE_REPLACE);

    // Reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_busy && !o_res_vld))
        else $error("block not idle after reset");

    // An empty-list error carries zero victim fields
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && o_result.list_empty_error) |->
        (o_result.victim_frame == '0 && o_result.victim_page == '0
         && !o_result.needs_write_back))
        else $error("error result carries victim data");

    // Only a replacement request can produce a result next cycle
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && (i_item.mode != MODE_REPLACE)) |=> !o_res_vld)
        else $error("result after a non-replacement request");

    // A replacement either starts a scan or reports an empty list
    a_rep_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_rep |=> (o_busy || (o_res_vld && o_result.list_empty_error)))
        else $error("replacement neither scanned nor flagged empty");

    // A victim is reported only at the end of a scan
    a_victim_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && !o_result.list_empty_error) |-> $past(o_busy))
        else $error("victim reported without a scan");

endmodule

bind lru_frame_victim_select_core lfv_checker u_lfv_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (i_start),
    .i_item    (i_item),
    .o_busy    (o_busy),
    .o_res_vld (o_res_vld),
    .o_result  (o_result)
);

@@ verif/lru_frame_victim_select_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_frame_victim_select_core_test
// Self-checking bench for the LRU frame victim selector. A short table of
// directed requests is run first: the empty list, the field extremes, stamp
// ties, duplicate pages and the full list. Random request streams follow in
// phases with and without sender gaps. Every request is fed to a behavioral
// model of the frame list, and each result strobe is checked field by field
// against the oldest victim still due.
// ----------------------------------------------------------------------------
module lru_frame_victim_select_core_test;
    import lfv_pkg::*;

    localparam int         SLOTS       = FRAME_COUNT_DEF;
    localparam logic [1:0] MODE_NONE   = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         PHASE_REQS  = 138;
    localparam int         SETTLE      = 2 * SLOTS + 8;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_start;
    t_item   i_item;
    logic    o_busy;
    logic    o_res_vld;
    t_result o_result;

    // Model of the frame list, oldest assignment first
    logic [FRAME_W-1:0] lst_frame [SLOTS];
    logic [PAGE_W-1:0]  lst_page  [SLOTS];
    logic [TIME_W-1:0]  lst_stamp [SLOTS];
    logic               lst_dirty [SLOTS];
    int                 lst_count;

    t_result victims_due [$];
    t_result due_head;
    int      mismatches;
    int      cycles;

    // Directed table: request, whether the victim is typed in, typed victim
    t_item   dir_req   [$];
    bit      dir_typed [$];
    t_result dir_want  [$];

    lru_frame_victim_select_core u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_item    (i_item),
        .o_busy    (o_busy),
        .o_res_vld (o_res_vld),
        .o_result  (o_result)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d victims outstanding", $time, victims_due.size());
            $display("lru_frame_victim_select_core test failed");
            $finish;
        end
    end

    function automatic t_item mk(input logic [1:0] mode, input logic [FRAME_W-1:0] frame,
                                 input logic [PAGE_W-1:0] page,
                                 input logic [TIME_W-1:0] stamp, input logic wr);
        t_item req;
        req.mode         = mode;
        req.frame_number = frame;
        req.page_number  = page;
        req.access_time  = stamp;
        req.write_access = wr;
        return req;
    endfunction

    // Apply one request to the list model; return 1 with the victim on replace
    function automatic bit lru_update(input t_item req, output t_result res);
        bit                has_res;
        int                pick;
        logic [TIME_W-1:0] best;
        has_res = 1'b0;
        res     = '0;
        pick    = 0;
        best    = '0;
        case (req.mode)
            MODE_ASSIGN: begin
                // drop assigns to a full list, load fresh pages clean
                if (lst_count < SLOTS) begin
                    lst_frame[lst_count] = req.frame_number;
                    lst_page[lst_count]  = req.page_number;
                    lst_stamp[lst_count] = req.access_time;
                    lst_dirty[lst_count] = 1'b0;
                    lst_count++;
                end
            end
            MODE_ACCESS: begin
                // refresh every entry holding the page
                for (int i = 0; i < lst_count; i++) begin
                    if (lst_page[i] == req.page_number) begin
                        lst_stamp[i] = req.access_time;
                        if (req.write_access)
                            lst_dirty[i] = 1'b1;
                    end
                end
            end
            MODE_REPLACE: begin
                has_res = 1'b1;
                if (lst_count == 0) begin
                    res.list_empty_error = 1'b1;
                end else begin
                    // oldest stamp wins, later entry on a tie
                    best = lst_stamp[0];
                    for (int i = 1; i < lst_count; i++) begin
                        if (lst_stamp[i] <= best) begin
                            best = lst_stamp[i];
                            pick = i;
                        end
                    end
                    res.victim_frame     = lst_frame[pick];
                    res.victim_page      = lst_page[pick];
                    res.needs_write_back = lst_dirty[pick];
                    // close the gap, keep the order
                    for (int i = pick; i + 1 < lst_count; i++) begin
                        lst_frame[i] = lst_frame[i + 1];
                        lst_page[i]  = lst_page[i + 1];
                        lst_stamp[i] = lst_stamp[i + 1];
                        lst_dirty[i] = lst_dirty[i + 1];
                    end
                    lst_count--;
                end
            end
            default: ;
        endcase
        return has_res;
    endfunction

    // Hold the request until taken, log its victim, then maybe go idle
    task automatic issue(input t_item req, input bit typed, input t_result want,
                         input int idle_pct);
        t_result got;
        bit      has_res;
        i_start <= 1'b1;
        i_item  <= req;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        has_res = lru_update(req, got);
        if (typed)
            victims_due.push_back(want);
        else if (has_res)
            victims_due.push_back(got);
        if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
            i_start <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(5, 40)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Stop requesting until every due victim has shown up
    task automatic drain_victims();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (victims_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic add_row(input t_item req, input bit typed, input t_result want);
        dir_req.push_back(req);
        dir_typed.push_back(typed);
        dir_want.push_back(want);
    endtask

    // Check each result strobe against the oldest due victim
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_vld) begin
            if (victims_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result frame=%0d page=%0d wb=%0b err=%0b", $time,
                         o_result.victim_frame, o_result.victim_page,
                         o_result.needs_write_back, o_result.list_empty_error);
            end else begin
                due_head = victims_due.pop_front();
                if (o_result.victim_frame !== due_head.victim_frame) begin
                    mismatches++;
                    $display("%0t: victim_frame expected %0d got %0d", $time,
                             due_head.victim_frame, o_result.victim_frame);
                end
                if (o_result.victim_page !== due_head.victim_page) begin
                    mismatches++;
                    $display("%0t: victim_page expected %0d got %0d", $time,
                             due_head.victim_page, o_result.victim_page);
                end
                if (o_result.needs_write_back !== due_head.needs_write_back) begin
                    mismatches++;
                    $display("%0t: needs_write_back expected %0b got %0b", $time,
                             due_head.needs_write_back, o_result.needs_write_back);
                end
                if (o_result.list_empty_error !== due_head.list_empty_error) begin
                    mismatches++;
                    $display("%0t: list_empty_error expected %0b got %0b", $time,
                             due_head.list_empty_error, o_result.list_empty_error);
                end
            end
        end
    end

    initial begin
        t_result           none;
        t_result           empty_err;
        t_result           tie_pick;
        t_item             req;
        int                idle_pct [4];
        int                pick_mode;
        logic [TIME_W-1:0] clock_now;
        none       = '0;
        empty_err  = '0;
        empty_err.list_empty_error = 1'b1;
        tie_pick   = '0;
        tie_pick.victim_frame     = 4'd5;
        tie_pick.victim_page      = 10'd1023;
        tie_pick.needs_write_back = 1'b1;
        mismatches = 0;
        cycles     = 0;
        lst_count  = 0;
        clock_now  = 32'd5000;
        // gaps per phase: none, heavy, none (receiver cannot stall), light
        idle_pct   = '{0, 46, 0, 13};

        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty list, idle code, unlisted page, extremes and ties
        add_row(mk(MODE_REPLACE, 4'd0, 10'd0, 32'd0, 1'b0), 1'b1, empty_err);
        add_row(mk(MODE_NONE, 4'hF, 10'h3FF, 32'hFFFF_FFFF, 1'b1), 1'b0, none);
        add_row(mk(MODE_ACCESS, 4'd0, 10'd7, 32'd9, 1'b1), 1'b0, none);
        add_row(mk(MODE_ASSIGN, 4'd0, 10'd0, 32'd0, 1'b0), 1'b0, none);
        add_row(mk(MODE_ASSIGN, 4'hF, 10'h3FF, 32'hFFFF_FFFF, 1'b1), 1'b0, none);
        add_row(mk(MODE_ASSIGN, 4'd5, 10'h3FF, 32'd0, 1'b0), 1'b0, none);
        // page listed twice: both copies refreshed and dirtied
        add_row(mk(MODE_ACCESS, 4'd0, 10'h3FF, 32'd100, 1'b1), 1'b0, none);
        add_row(mk(MODE_REPLACE, 4'd0, 10'd0, 32'd0, 1'b0), 1'b0, none);
        add_row(mk(MODE_REPLACE, 4'd0, 10'd0, 32'd0, 1'b0), 1'b1, tie_pick);
        // fill the list, then overflow it
        for (int k = 0; k < SLOTS - 1; k++)
            add_row(mk(MODE_ASSIGN, 4'(k), 10'(k * 67), 32'(200 + (k % 5)), 1'b0),
                    1'b0, none);
        add_row(mk(MODE_ASSIGN, 4'd9, 10'd555, 32'd1, 1'b0), 1'b0, none);
        add_row(mk(MODE_ACCESS, 4'd0, 10'd0, 32'hFFFF_FFFF, 1'b0), 1'b0, none);
        add_row(mk(MODE_REPLACE, 4'd0, 10'd0, 32'd0, 1'b0), 1'b0, none);

        for (int k = 0; k < dir_req.size(); k++)
            issue(dir_req[k], dir_typed[k], dir_want[k], 0);
        drain_victims();

        // Random: mostly well-formed traffic on listed pages, some noise
        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < PHASE_REQS; n++) begin
                req = '0;
                req.frame_number = 4'($urandom_range(0, 15));
                req.page_number  = 10'($urandom_range(0, 1023));
                req.write_access = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 9))
                    0: req.access_time = $urandom;
                    1: req.access_time = clock_now;
                    default: begin
                        clock_now = clock_now + 32'($urandom_range(1, 3));
                        req.access_time = clock_now;
                    end
                endcase
                pick_mode = $urandom_range(0, 99);
                if (pick_mode < 4) begin
                    req.mode = MODE_NONE;
                end else if (pick_mode < 8) begin
                    req.mode = MODE_ACCESS;
                end else if (lst_count == 0) begin
                    if (pick_mode < 12)
                        req.mode = MODE_REPLACE;
                    else
                        req.mode = MODE_ASSIGN;
                end else if (pick_mode < 40) begin
                    req.mode = MODE_ASSIGN;
                    // reload a listed page now and then
                    if (pick_mode < 14)
                        req.page_number = lst_page[$urandom_range(0, lst_count - 1)];
                end else if (pick_mode < 75) begin
                    req.mode = MODE_ACCESS;
                    req.page_number = lst_page[$urandom_range(0, lst_count - 1)];
                end else begin
                    req.mode = MODE_REPLACE;
                end
                issue(req, 1'b0, none, idle_pct[ph]);
            end
            drain_victims();
        end

        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && victims_due.size() == 0)
            $display("lru_frame_victim_select_core test passed");
        else
            $display("lru_frame_victim_select_core test failed");
        $finish;
    end

endmodule
